/* hdl/ordered_list_insert_erase_macros.svh */
// ============================================================================
// ordered_list_insert_erase_macros.svh
// Assertion shorthands for the ordered list checker. All of them sample on
// clk_i and are disabled while rst_ni is low.
// ============================================================================
`ifndef ORDERED_LIST_INSERT_ERASE_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_MACROS_SVH

// plain property
`define OLIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define OLIE_ASSERT_NOW(lbl, ante, cons, msg) \
  `OLIE_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define OLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OLIE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hdl/olie_pkg.sv */
// ============================================================================
// olie_pkg
// Types and codes shared by the ordered list controller, datapath, top level
// and checker.
// ============================================================================
`default_nettype none

package olie_pkg;

  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned POS_BITS    = 4;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned COUNT_BITS  = 5;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_READ   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]   read_data;
    logic [COUNT_BITS-1:0]  count;
    logic [STATUS_BITS-1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE
  } state_e;

  typedef enum logic [1:0] {
    R_POS,
    R_PREV,
    R_NEXT
  } rsrc_e;

  typedef enum logic [1:0] {
    W_TAIL,
    W_SHIFT,
    W_POS
  } wsrc_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POS,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    capture;
    logic    mem_we;
    wsrc_e   wsrc;
    rsrc_e   rsrc;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    finish;
    logic    take_rdata;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic pos_ok;
    logic full;
    logic empty;
    logic ers_shift;
    logic ins_last;
    logic ers_more;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/ordered_list_insert_erase.sv */
// ============================================================================
// ordered_list_insert_erase
// Bounded ordered list of words with read, push, pop, insert and erase.
// ============================================================================
// Usage:
//   A request (req_i: operation, position, value) is taken at a clock edge
//   with start high and busy low. Exactly one response (rsp_o: read_data,
//   count, status) follows, shown for one cycle with done_o high. The
//   receiver cannot hold it off; it must take it in that cycle.
//   Sequencer states passed from the accepting edge on:
//     push, pop, errors, unknown codes: S_EXEC
//     read:                             S_EXEC, S_READ
//     insert at p with count n:         S_EXEC, n - p shifts, S_PLACE
//     erase at p with count n:          S_EXEC, n - 1 - p shifts
//   busy drops in the cycle done_o is high, so the next request can be
//   taken in that cycle. Entries live in a single-port-pair RAM; each
//   shift reads one entry in S_SHIFT_RD and writes it in S_SHIFT_WR.
//   Reset clears the element count and the sequencer; RAM contents are not
//   cleared, entries at and above count are never read.
// ============================================================================
`default_nettype none

module ordered_list_insert_erase #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  olie_pkg::req_t  req_i,
  output logic            done_o,
  output olie_pkg::rsp_t  rsp_o
);

  import olie_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  olie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  olie_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

/* hdl/olie_ram.sv */
// ============================================================================
// olie_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module olie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/olie_ctrl.sv */
// ============================================================================
// olie_ctrl
// Sequencer for the ordered list: decodes the captured request against the
// datapath status and steps the entry shifts one read and one write at a time.
// ============================================================================
`default_nettype none

module olie_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  olie_pkg::dp_stat_t   stat_i,
  output olie_pkg::ctrl_cmd_t  cmd_o
);

  import olie_pkg::*;

  state_e state_q, state_d;
  logic   is_insert;

  assign is_insert = (stat_i.op == OP_INSERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (stat_i.op)
          OP_READ: begin
            if (stat_i.pos_ok) state_d = S_READ;
          end
          OP_INSERT: begin
            if (stat_i.pos_ok && !stat_i.full) state_d = S_SHIFT_RD;
          end
          OP_ERASE: begin
            if (stat_i.pos_ok && stat_i.ers_shift) state_d = S_SHIFT_RD;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (is_insert) begin
          state_d = stat_i.ins_last ? S_PLACE : S_SHIFT_RD;
        end else begin
          state_d = stat_i.ers_more ? S_SHIFT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '{capture: 1'b0, mem_we: 1'b0, wsrc: W_TAIL, rsrc: R_POS,
              idx_op: IDX_HOLD, cnt_op: CNT_HOLD, finish: 1'b0,
              take_rdata: 1'b0, status: ST_OK};
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_READ: begin
            cmd_o.rsrc = R_POS;
            if (!stat_i.pos_ok) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_RANGE;
            end
          end
          OP_PUSH: begin
            cmd_o.finish = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.mem_we = 1'b1;
              cmd_o.wsrc   = W_TAIL;
              cmd_o.cnt_op = CNT_INC;
            end
          end
          OP_POP: begin
            cmd_o.finish = 1'b1;
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.cnt_op = CNT_DEC;
            end
          end
          OP_INSERT: begin
            if (!stat_i.pos_ok) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_RANGE;
            end else if (stat_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.idx_op = IDX_CNT;
            end
          end
          OP_ERASE: begin
            if (!stat_i.pos_ok) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_RANGE;
            end else if (stat_i.ers_shift) begin
              cmd_o.idx_op = IDX_POS;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.cnt_op = CNT_DEC;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
          end
        endcase
      end
      S_READ: begin
        cmd_o.finish     = 1'b1;
        cmd_o.take_rdata = 1'b1;
      end
      S_SHIFT_RD: begin
        cmd_o.rsrc = is_insert ? R_PREV : R_NEXT;
      end
      S_SHIFT_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsrc   = W_SHIFT;
        if (is_insert) begin
          cmd_o.idx_op = IDX_DEC;
        end else begin
          cmd_o.idx_op = IDX_INC;
          if (!stat_i.ers_more) begin
            cmd_o.finish = 1'b1;
            cmd_o.cnt_op = CNT_DEC;
          end
        end
      end
      S_PLACE: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsrc   = W_POS;
        cmd_o.cnt_op = CNT_INC;
        cmd_o.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/olie_dp.sv */
// ============================================================================
// olie_dp
// Ordered list datapath: request registers, element count, shift index,
// element RAM and the registered result.
// ============================================================================
`default_nettype none

module olie_dp #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  olie_pkg::req_t       req_i,
  input  olie_pkg::ctrl_cmd_t  cmd_i,
  output olie_pkg::dp_stat_t   stat_o,
  output logic                 done_o,
  output olie_pkg::rsp_t       rsp_o
);

  import olie_pkg::*;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam int unsigned E_W    = CMP_W + 1;
  localparam int unsigned IE_W   = CNT_W + 1;
  localparam int unsigned VAL_W  = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;
  localparam int unsigned RD_W   = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;
  localparam int unsigned OC_W   = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

  logic [OP_BITS-1:0]   op_q;
  logic [POS_BITS-1:0]  pos_q;
  logic [WORD_BITS-1:0] val_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic                 done_q;
  rsp_t                 rsp_q, rsp_d;

  logic [VAL_W-1:0]     val_ext;
  logic [RD_W-1:0]      rd_ext;
  logic [OC_W-1:0]      cnt_out_ext;
  logic [CMP_W-1:0]     pos_cmp, cnt_cmp;
  logic [E_W-1:0]       pos_p1;
  logic [IE_W-1:0]      idx_p2;
  logic [ADDR_W-1:0]    pos_addr, cnt_addr, idx_m1, idx_p1;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  assign val_ext  = VAL_W'(req_i.value);
  assign pos_cmp  = CMP_W'(pos_q);
  assign cnt_cmp  = CMP_W'(count_q);
  assign pos_addr = pos_cmp[ADDR_W-1:0];
  assign cnt_addr = count_q[ADDR_W-1:0];
  assign idx_m1   = idx_q - ADDR_W'(1);
  assign idx_p1   = idx_q + ADDR_W'(1);
  assign pos_p1   = E_W'(pos_cmp) + E_W'(1);
  assign idx_p2   = IE_W'(idx_q) + IE_W'(2);

  assign stat_o.op        = op_e'(op_q);
  assign stat_o.pos_ok    = (pos_cmp < cnt_cmp);
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.ers_shift = (pos_p1 < E_W'(cnt_cmp));
  assign stat_o.ins_last  = (idx_m1 == pos_addr);
  assign stat_o.ers_more  = (idx_p2 < IE_W'(count_q));

  always_comb begin
    case (cmd_i.rsrc)
      R_POS:   raddr = pos_addr;
      R_PREV:  raddr = idx_m1;
      R_NEXT:  raddr = idx_p1;
      default: raddr = pos_addr;
    endcase
  end

  always_comb begin
    case (cmd_i.wsrc)
      W_TAIL: begin
        waddr = cnt_addr;
        wdata = val_q;
      end
      W_SHIFT: begin
        waddr = idx_q;
        wdata = rdata;
      end
      W_POS: begin
        waddr = pos_addr;
        wdata = val_q;
      end
      default: begin
        waddr = cnt_addr;
        wdata = val_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_CNT:  idx_d = cnt_addr;
      IDX_POS:  idx_d = pos_addr;
      IDX_DEC:  idx_d = idx_m1;
      IDX_INC:  idx_d = idx_p1;
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_q - CNT_W'(1);
      default:  count_d = count_q;
    endcase
  end

  assign rd_ext      = RD_W'(rdata);
  assign cnt_out_ext = OC_W'(count_d);

  always_comb begin
    rsp_d.read_data = cmd_i.take_rdata ? rd_ext[DATA_BITS-1:0] : '0;
    rsp_d.count     = cnt_out_ext[COUNT_BITS-1:0];
    rsp_d.status    = cmd_i.status;
  end

  olie_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_i.operation;
      pos_q <= req_i.position;
      val_q <= val_ext[WORD_BITS-1:0];
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

/* hdl/olie_checker.sv */
// ============================================================================
// olie_checker
// Port-level checks for the ordered list, bound to the top level.
// ============================================================================
`default_nettype none

`include "ordered_list_insert_erase_macros.svh"

module olie_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_i,
  input olie_pkg::req_t  req_i,
  input logic            done_i,
  input olie_pkg::rsp_t  rsp_i
);

  import olie_pkg::*;

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

  logic unused_req;
  assign unused_req = ^req_i;

  `OLIE_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i && !done_i, "no busy after accept")
  `OLIE_ASSERT_NOW(a_done_idle, done_i, !busy_i, "done while busy")
  `OLIE_ASSERT_NOW(a_data_ok, done_i && rsp_i.read_data != '0, rsp_i.status == ST_OK, "data on error")
  `OLIE_ASSERT_NOW(a_empty_zero, done_i && rsp_i.status == ST_EMPTY, rsp_i.count == '0, "empty count")
  `OLIE_ASSERT_NOW(a_full_cnt, done_i && rsp_i.status == ST_FULL, rsp_i.count == FULL_COUNT, "full count")

endmodule

bind ordered_list_insert_erase olie_checker #(
  .DEPTH (DEPTH)
) u_olie_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .req_i   (req_i),
  .done_i  (done_o),
  .rsp_i   (rsp_o)
);

`default_nettype wire

/* test/ordered_list_insert_erase_tb.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_tb
// Self-checking bench for the bounded ordered list. Requests are sent through
// the start/busy handshake with random gaps. Each accepted request updates a
// shadow copy of the list, and the resulting response is queued. Every done_o
// cycle is checked field by field against the oldest queued response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_erase_tb;

  import olie_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [OP_BITS-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0] OP_UNUSED_LAST  = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  // shadow list
  logic [DATA_BITS-1:0]  list_mem [LIST_DEPTH];
  logic [COUNT_BITS-1:0] list_len = '0;

  rsp_t pending_rsp_q [$];
  rsp_t want_rsp;
  rsp_t next_rsp;

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          no_idle        = 1'b0;

  ordered_list_insert_erase dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic req_t mk_req(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] pos,
                                  logic [VALUE_BITS-1:0] val);
    req_t r;
    r.operation = op;
    r.position  = pos;
    r.value     = val;
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Applies one request to the shadow list and returns its response.
  task automatic apply_to_list(input req_t r, output rsp_t e);
    int i;
    e.read_data = '0;
    e.status    = ST_OK;
    case (r.operation)
      OP_READ: begin
        if (r.position < list_len) e.read_data = list_mem[r.position];
        else e.status = ST_RANGE;
      end
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          e.status = ST_FULL;
        end else begin
          list_mem[list_len] = r.value;
          list_len = list_len + 1'b1;
        end
      end
      OP_POP: begin
        if (list_len == 0) e.status = ST_EMPTY;
        else list_len = list_len - 1'b1;
      end
      OP_INSERT: begin
        if (r.position >= list_len) begin
          e.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          e.status = ST_FULL;
        end else begin
          for (i = int'(list_len); i > int'(r.position); i--) list_mem[i] = list_mem[i-1];
          list_mem[r.position] = r.value;
          list_len = list_len + 1'b1;
        end
      end
      OP_ERASE: begin
        if (r.position >= list_len) begin
          e.status = ST_RANGE;
        end else begin
          for (i = int'(r.position); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len = list_len - 1'b1;
        end
      end
      default: ;
    endcase
    e.count = list_len;
  endtask

  // Response check first, then record the transaction taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected response rd=%h cnt=%0d st=%0d", $realtime,
                     rsp_o.read_data, rsp_o.count, rsp_o.status);
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          if (rsp_o.read_data !== want_rsp.read_data || rsp_o.count !== want_rsp.count ||
              rsp_o.status !== want_rsp.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch exp rd=%h cnt=%0d st=%0d got rd=%h cnt=%0d st=%0d",
                       $realtime, want_rsp.read_data, want_rsp.count, want_rsp.status,
                       rsp_o.read_data, rsp_o.count, rsp_o.status);
          end
        end
      end
      if (start && !busy) begin
        apply_to_list(req_i, next_rsp);
        pending_rsp_q.push_back(next_rsp);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Returns at the edge where the transaction is taken.
  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic test_empty_list();
    send_req(mk_req(OP_POP, '0, '1));
    send_req(mk_req(OP_READ, '0, '0));
    send_req(mk_req(OP_INSERT, '0, '1));
    send_req(mk_req(OP_ERASE, '1, '0));
    send_req(mk_req(OP_UNUSED_FIRST, '1, '1));
    send_req(mk_req(OP_UNUSED_LAST, '0, '0));
  endtask

  task automatic test_fill_and_full();
    int i;
    for (i = 0; i < LIST_DEPTH; i++)
      send_req(mk_req(OP_PUSH, 4'(i), (i == 0) ? '0 : (i == 1) ? '1 : $urandom));
    send_req(mk_req(OP_PUSH, '0, $urandom));
    send_req(mk_req(OP_INSERT, '1, $urandom));
  endtask

  task automatic test_shift_edges();
    send_req(mk_req(OP_ERASE, '0, '0));
    send_req(mk_req(OP_INSERT, 4'd14, '1));
    send_req(mk_req(OP_READ, '1, '0));
    send_req(mk_req(OP_ERASE, '1, '0));
    send_req(mk_req(OP_READ, '1, '0));
  endtask

  // Mostly legal requests, drifting between full and empty.
  task automatic test_random_ops(input int unsigned n_items);
    int unsigned k;
    int unsigned pick;
    bit          growing;
    logic [OP_BITS-1:0]  op;
    logic [POS_BITS-1:0] pos;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (list_len >= LIST_DEPTH) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = ~growing;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = 3'($urandom);
      else if (growing)
        op = (pick < 35) ? OP_PUSH : (pick < 60) ? OP_INSERT : (pick < 80) ? OP_READ :
             (pick < 88) ? OP_POP : OP_ERASE;
      else
        op = (pick < 13) ? OP_PUSH : (pick < 23) ? OP_INSERT : (pick < 43) ? OP_READ :
             (pick < 70) ? OP_POP : OP_ERASE;
      if (list_len > 0 && $urandom_range(0, 3) != 0)
        pos = 4'($urandom_range(int'(list_len) - 1, 0));
      else
        pos = 4'($urandom);
      send_req(mk_req(op, pos, pick_value()));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_full();
    test_shift_edges();
    test_random_ops(520);
    no_idle = 1'b1;
    test_random_ops(250);
    no_idle = 1'b0;
    test_random_ops(250);
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
